// ===== rtl/ostb_pkg.sv =====
// Shared types and constants for the one-shot timer bank.
// Holds the transaction payload structs, the operation codes, the stored entry
// layout and the sequencer states. No dependencies.
`timescale 1ns / 1ps

package ostb_pkg;

    localparam int FUNC_W  = 4;
    localparam int ID_W    = 4;
    localparam int VALUE_W = 16;
    localparam int COUNT_W = 16;
    localparam int MASK_W  = 16;

    typedef enum logic [FUNC_W-1:0] {
        FN_TICK      = 4'd0,
        FN_CREATE    = 4'd1,
        FN_DELETE    = 4'd2,
        FN_START     = 4'd3,
        FN_RESTART   = 4'd4,
        FN_STOP      = 4'd5,
        FN_CLR_COUNT = 4'd6,
        FN_SET_LIMIT = 4'd7,
        FN_QUERY     = 4'd8,
        FN_CLR_EXP   = 4'd9
    } t_func;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [ID_W-1:0]    timer_id;
        logic [VALUE_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic               status;
        logic               timed_out;
        logic [COUNT_W-1:0] tick_count;
        logic [COUNT_W-1:0] tick_limit;
        logic [MASK_W-1:0]  expired_mask;
    } t_out;

    typedef struct packed {
        logic               in_use;
        logic               running;
        logic [COUNT_W-1:0] count;
        logic [COUNT_W-1:0] limit;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WORK,
        ST_RESP
    } t_state;

endpackage

// ===== rtl/ostb_entry_mem.sv =====
// Timer entry store: one synchronous write port and one registered read port.
// Per-entry valid bits make an entry read as all zero until it is first written.
// Depends on ostb_pkg for the entry layout.
`timescale 1ns / 1ps

module ostb_entry_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rd_en,
    input  logic [AW-1:0]         i_rd_addr,
    output ostb_pkg::t_entry      o_rd_data,
    input  logic                  i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,
    input  ostb_pkg::t_entry      i_wr_data
);
    import ostb_pkg::*;

    t_entry             r_mem [DEPTH];
    logic [DEPTH-1:0]   r_vld;
    t_entry             r_rd_data;
    logic               r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// ===== rtl/ostb_alu.sv =====
// Read-modify-write logic for one timer entry.
// Applies a tick or one addressed operation to an entry and its expired flag.
// Depends on ostb_pkg for operation codes and the entry layout.
`timescale 1ns / 1ps

module ostb_alu (
    input  logic [ostb_pkg::FUNC_W-1:0]  i_func,
    input  logic [ostb_pkg::VALUE_W-1:0] i_value,
    input  ostb_pkg::t_entry             i_entry,
    input  logic                         i_exp,
    output ostb_pkg::t_entry             o_entry,
    output logic                         o_exp,
    output logic                         o_status
);
    import ostb_pkg::*;

    logic [COUNT_W-1:0] inc;

    assign inc = i_entry.count + COUNT_W'(1);

    always_comb begin
        o_entry  = i_entry;
        o_exp    = i_exp;
        o_status = 1'b0;
        case (i_func)
            FN_TICK: begin
                if (i_entry.in_use && i_entry.running) begin
                    if (inc == i_entry.limit) begin
                        o_exp           = 1'b1;
                        o_entry.count   = '0;
                        o_entry.running = 1'b0;
                    end else begin
                        o_entry.count = inc;
                    end
                end
            end
            FN_CREATE: begin
                if (i_entry.in_use) begin
                    o_status = 1'b1;
                end else begin
                    o_entry.limit   = i_value;
                    o_entry.count   = '0;
                    o_entry.in_use  = 1'b1;
                    o_entry.running = 1'b0;
                    o_exp           = 1'b0;
                end
            end
            FN_DELETE: begin
                if (!i_entry.in_use) begin
                    o_status = 1'b1;
                end else begin
                    o_entry.in_use  = 1'b0;
                    o_entry.running = 1'b0;
                    o_exp           = 1'b0;
                end
            end
            FN_START: begin
                o_entry.running = 1'b1;
            end
            FN_RESTART: begin
                o_exp           = 1'b0;
                o_entry.running = 1'b1;
            end
            FN_STOP: begin
                o_entry.running = 1'b0;
            end
            FN_CLR_COUNT: begin
                o_entry.count = '0;
            end
            FN_SET_LIMIT: begin
                o_entry.limit = i_value;
            end
            FN_CLR_EXP: begin
                o_exp = 1'b0;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/one_shot_timer_bank.sv =====
// Top level of the one-shot timer bank: sequencer, expired flags and output register.
// Instantiates ostb_entry_mem and ostb_alu; depends on ostb_pkg.
//
//  Channel | Valid        | Stall        | Payload
//  --------+--------------+--------------+----------------------
//  input   | i_in_valid   | o_in_stall   | i_in_data  (t_in)
//  output  | o_out_valid  | i_out_stall  | o_out_data (t_out)
//
// An addressed operation is read from the entry memory on acceptance, updated and written
// back in the work state, and loaded into the output register from the response state.
// A tick sweeps the entry memory one entry a cycle in the work state, from entry 0 to
// entry NUM_TIMERS - 1, before it moves to the response state.
// The single read port of the entry memory limits the sweep to one entry a cycle.
// Reset clears the state and the valid bits of the memory.
// A stalled result holds the sequencer in its response state, so at most one more
// transaction is taken until it moves.
`timescale 1ns / 1ps

module one_shot_timer_bank #(
    parameter int NUM_TIMERS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  ostb_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output ostb_pkg::t_out o_out_data
);
    import ostb_pkg::*;

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

    t_state                  r_state, n_state;
    t_in                     r_req, n_req;
    logic [IDX_W-1:0]        r_idx, n_idx;
    logic [IDX_W-1:0]        r_id_addr, n_id_addr;
    logic                    r_id_vld, n_id_vld;
    t_out                    r_res, n_res;
    t_out                    r_out, n_out;
    logic                    r_out_vld, n_out_vld;
    logic [NUM_TIMERS-1:0]   r_expired, n_expired;

    logic                    in_acc;
    logic [ID_W+IDX_W-1:0]   id_ext;
    logic                    in_tick;
    logic                    req_tick;
    logic                    last;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic                    wr_en;
    t_entry                  rd_data;
    t_entry                  alu_entry;
    logic                    alu_exp;
    logic                    alu_status;
    logic                    cur_exp;
    logic [NUM_TIMERS+MASK_W-1:0] mask_pad;

    ostb_entry_mem #(
        .DEPTH (NUM_TIMERS),
        .AW    (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_idx),
        .i_wr_data (alu_entry)
    );

    ostb_alu u_alu (
        .i_func   (r_req.func),
        .i_value  (r_req.value),
        .i_entry  (rd_data),
        .i_exp    (cur_exp),
        .o_entry  (alu_entry),
        .o_exp    (alu_exp),
        .o_status (alu_status)
    );

    assign in_acc   = i_in_valid && !o_in_stall;
    assign id_ext   = {{IDX_W{1'b0}}, i_in_data.timer_id};
    assign in_tick  = (i_in_data.func == FN_TICK);
    assign req_tick = (r_req.func == FN_TICK);
    assign cur_exp  = r_id_vld || req_tick ? r_expired[r_idx] : 1'b0;
    assign last     = !req_tick || (r_idx == LAST_IDX);
    assign mask_pad = {{MASK_W{1'b0}}, n_expired};

    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_idx     = r_idx;
        n_id_addr = r_id_addr;
        n_id_vld  = r_id_vld;
        n_res     = r_res;
        n_out     = r_out;
        n_out_vld = r_out_vld && i_out_stall;
        n_expired = r_expired;
        rd_en     = 1'b0;
        rd_addr   = r_idx;
        wr_en     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state   = ST_WORK;
                    n_req     = i_in_data;
                    n_id_addr = id_ext[IDX_W-1:0];
                    n_id_vld  = (32'(i_in_data.timer_id) < NUM_TIMERS);
                    n_idx     = in_tick ? '0 : id_ext[IDX_W-1:0];
                    n_res     = '0;
                    rd_en     = in_tick || n_id_vld;
                    rd_addr   = n_idx;
                end
            end
            ST_WORK: begin
                if (req_tick || r_id_vld) begin
                    wr_en            = 1'b1;
                    n_expired[r_idx] = alu_exp;
                end
                if (r_id_vld && (!req_tick || (r_idx == r_id_addr))) begin
                    n_res.timed_out  = alu_exp;
                    n_res.tick_count = alu_entry.count;
                    n_res.tick_limit = alu_entry.limit;
                end
                if (last) begin
                    n_res.status       = r_id_vld && !req_tick && alu_status;
                    n_res.expired_mask = mask_pad[MASK_W-1:0];
                    n_state            = ST_RESP;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    rd_en   = 1'b1;
                    rd_addr = n_idx;
                end
            end
            ST_RESP: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
            r_expired <= '0;
            r_id_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_expired <= n_expired;
            r_id_vld  <= n_id_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_idx     <= n_idx;
        r_id_addr <= n_id_addr;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    a_reset_clears_expired: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_expired == '0))
        else $error("expired flags not cleared by reset");

    a_accept_starts_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == ST_WORK))
        else $error("accepted transaction did not start work");

    a_result_from_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_RESP))
        else $error("result loaded outside the response state");

    a_sweep_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WORK && req_tick) |-> (r_idx <= LAST_IDX))
        else $error("tick sweep index beyond last timer");

endmodule
